// ===== hw/rtl/fhp_pkg.sv =====
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types and constants for the fragment header parser.
// ----------------------------------------------------------------------------
package fhp_pkg;

	// Result codes carried on the kind field
	typedef enum logic [1:0] {
		KIND_HDR_OK  = 2'd0,
		KIND_BLOB    = 2'd1,
		KIND_LEN_ERR = 2'd2,
		KIND_ZERO_ID = 2'd3
	} kind_t;

	localparam int unsigned HDR_BYTES = 21;
	localparam int unsigned CNT_W     = 5;

	// Header byte positions
	localparam logic [CNT_W-1:0] OBJ_END   = CNT_W'(8);
	localparam logic [CNT_W-1:0] FRG_END   = CNT_W'(16);
	localparam logic [CNT_W-1:0] FLAGS_POS = CNT_W'(16);
	localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(HDR_BYTES - 1);

	localparam logic [31:0] MAX_BLOB_LEN_RST = 32'h0000_FFFF;

endpackage

// ===== hw/rtl/fragment_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// fragment_header_parser_core
// Byte-serial decoder for packet fragments: collects the 21-byte header,
// reports it or its error, then passes the blob bytes through.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------
//  in        sink       in_valid / in_stall    in_byte
//  out       source     out_valid / out_stall  kind, ids, flags, length, blob
//  cfg       sink       cfg_we                 cfg_wdata (max_blob_len)
//
//  One word per cycle while in_stall is low: the header counter, the blob
//  counter and the result register each update on every accepted word.
//  A result appears on the output in the cycle after its word is taken.
//  in_stall rises only while a result sits in the output register and the
//  sink stalls it; words that give no result still wait for that slot.
//  Reset clears the counters, the header fields and the output valid, and
//  loads max_blob_len with 65535.
//
module fragment_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// results out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [63:0] object_ident,
	output logic [63:0] fragment_ident,
	output logic        start_flag,
	output logic        end_flag,
	output logic [31:0] blob_length,
	output logic [7:0]  blob_byte,
	output logic        last_blob_byte,
	// configuration
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// Configuration and parse state
	logic [31:0]                 max_blob_len_q;
	logic [fhp_pkg::CNT_W-1:0]   header_count_q;
	logic [63:0]                 object_shift_q;
	logic [63:0]                 fragment_shift_q;
	logic [7:0]                  flags_q;
	logic [31:0]                 length_shift_q;
	logic [31:0]                 blob_remaining_q;

	// Output register
	logic                        out_valid_q;
	fhp_pkg::kind_t              kind_q;
	logic [63:0]                 object_q;
	logic [63:0]                 fragment_q;
	logic [7:0]                  flags_out_q;
	logic [31:0]                 length_out_q;
	logic [7:0]                  blob_byte_q;
	logic                        last_q;

	// Next-state and result logic
	logic                        out_free;
	logic                        in_acc;
	logic                        blob_phase;
	logic [fhp_pkg::CNT_W-1:0]   header_count_d;
	logic [63:0]                 object_d;
	logic [63:0]                 fragment_d;
	logic [7:0]                  flags_d;
	logic [31:0]                 length_d;
	logic [31:0]                 blob_remaining_d;
	logic                        res_valid;
	fhp_pkg::kind_t              res_kind;
	logic [7:0]                  res_byte;
	logic                        res_last;

	// The output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !out_free;
	assign in_acc   = in_valid && out_free;

	assign blob_phase = (blob_remaining_q != 32'd0);

	always_comb begin
		header_count_d   = header_count_q;
		object_d         = object_shift_q;
		fragment_d       = fragment_shift_q;
		flags_d          = flags_q;
		length_d         = length_shift_q;
		blob_remaining_d = blob_remaining_q;
		res_valid        = 1'b0;
		res_kind         = fhp_pkg::KIND_HDR_OK;
		res_byte         = 8'd0;
		res_last         = 1'b0;

		if (blob_phase) begin
			// Pass the payload byte through, flag the final one
			blob_remaining_d = blob_remaining_q - 32'd1;
			res_valid        = 1'b1;
			res_kind         = fhp_pkg::KIND_BLOB;
			res_byte         = in_byte;
			res_last         = (blob_remaining_q == 32'd1);
		end else begin
			// Shift the header byte into its field, MSB first
			if (header_count_q < fhp_pkg::OBJ_END) begin
				object_d = {object_shift_q[55:0], in_byte};
			end else if (header_count_q < fhp_pkg::FRG_END) begin
				fragment_d = {fragment_shift_q[55:0], in_byte};
			end else if (header_count_q == fhp_pkg::FLAGS_POS) begin
				flags_d = in_byte;
			end else begin
				length_d = {length_shift_q[23:0], in_byte};
			end

			if (header_count_q != fhp_pkg::HDR_LAST) begin
				header_count_d = header_count_q + 1'b1;
			end else begin
				// Header complete: length error wins over zero id
				header_count_d = '0;
				res_valid      = 1'b1;
				if (length_d > max_blob_len_q) begin
					res_kind = fhp_pkg::KIND_LEN_ERR;
				end else if (object_d == 64'd0) begin
					res_kind = fhp_pkg::KIND_ZERO_ID;
				end else begin
					res_kind         = fhp_pkg::KIND_HDR_OK;
					blob_remaining_d = length_d;
				end
			end
		end
	end

	// Parse state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_blob_len_q   <= fhp_pkg::MAX_BLOB_LEN_RST;
			header_count_q   <= '0;
			object_shift_q   <= '0;
			fragment_shift_q <= '0;
			flags_q          <= '0;
			length_shift_q   <= '0;
			blob_remaining_q <= '0;
		end else begin
			if (cfg_we) begin
				max_blob_len_q <= cfg_wdata;
			end
			// Advance only on an accepted word
			if (in_acc) begin
				header_count_q   <= header_count_d;
				object_shift_q   <= object_d;
				fragment_shift_q <= fragment_d;
				flags_q          <= flags_d;
				length_shift_q   <= length_d;
				blob_remaining_q <= blob_remaining_d;
			end
		end
	end

	// Output valid: load on a result, drop when drained with nothing new
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_acc && res_valid;
		end
	end

	// Output payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_acc && res_valid) begin
			kind_q       <= res_kind;
			object_q     <= object_d;
			fragment_q   <= fragment_d;
			flags_out_q  <= flags_d;
			length_out_q <= length_d;
			blob_byte_q  <= res_byte;
			last_q       <= res_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign object_ident   = object_q;
	assign fragment_ident = fragment_q;
	assign start_flag     = flags_out_q[0];
	assign end_flag       = flags_out_q[1];
	assign blob_length    = length_out_q;
	assign blob_byte      = blob_byte_q;
	assign last_blob_byte = last_q;

endmodule

// ===== hw/rtl/fhp_checker.sv =====
// ----------------------------------------------------------------------------
// fhp_checker
// Port-level checks for the fragment header parser, bound to the top level.
// ----------------------------------------------------------------------------
module fhp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_stall,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] object_ident,
	input  logic [7:0]  blob_byte,
	input  logic        last_blob_byte
);

	// A stalled result holds its kind and payload byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(blob_byte))
		else $error("stalled result changed");

	// A held result blocks the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result is stalled");

	// Byte and last marker only on blob results
	a_blob_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != fhp_pkg::KIND_BLOB) |-> (blob_byte == 8'd0) && !last_blob_byte)
		else $error("blob fields set on a header result");

	// Zero-id error carries a zero id, an accepted header a nonzero one
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fhp_pkg::KIND_ZERO_ID) |-> (object_ident == 64'd0))
		else $error("zero-id error with nonzero id");

	a_hdr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fhp_pkg::KIND_HDR_OK) |-> (object_ident != 64'd0))
		else $error("header accepted with zero id");

endmodule

bind fragment_header_parser_core fhp_checker u_fhp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.kind           (kind),
	.object_ident   (object_ident),
	.blob_byte      (blob_byte),
	.last_blob_byte (last_blob_byte)
);

// ===== dv/tb_fragment_header_parser_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fragment_header_parser_core
// Self-checking bench for the fragment header parser. A byte stream of
// fragments, truncated headers and error headers is fed through the core
// under random idling on both sides, across several max_blob_len settings.
// Every accepted byte runs through a local decoder, and each report that
// leaves the core is checked field by field against the oldest one due.
// ----------------------------------------------------------------------------
module tb_fragment_header_parser_core;

	// State of one byte-serial decoder: the limit, the header collector and
	// the count of payload bytes still to pass.
	typedef struct {
		logic [31:0] max_len;
		int unsigned hdr_cnt;
		logic [63:0] obj_key;
		logic [63:0] frag_key;
		logic [7:0]  flags;
		logic [31:0] length;
		logic [31:0] blob_left;
	} parse_state_t;

	// One report as it leaves the core
	typedef struct {
		fhp_pkg::kind_t kind;
		logic [63:0]    obj_key;
		logic [63:0]    frag_key;
		logic           start_bit;
		logic           end_bit;
		logic [31:0]    length;
		logic [7:0]     data;
		logic           last_byte;
	} frag_report_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte   = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [63:0] object_ident;
	logic [63:0] fragment_ident;
	logic        start_flag;
	logic        end_flag;
	logic [31:0] blob_length;
	logic [7:0]  blob_byte;
	logic        last_blob_byte;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = 32'h0;

	parse_state_t parser_state;        // tracks the core, word by word as accepted
	parse_state_t plan_state;          // tracks the stream as it is being built
	frag_report_t reports_due[$];
	logic [7:0]   pending_bytes[$];
	int unsigned  planned_bytes;
	int unsigned  error_count   = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	logic         in_taken      = 1'b0;
	logic         long_hold_req = 1'b0;
	int unsigned  hold_left     = 0;

	fragment_header_parser_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.object_ident   (object_ident),
		.fragment_ident (fragment_ident),
		.start_flag     (start_flag),
		.end_flag       (end_flag),
		.blob_length    (blob_length),
		.blob_byte      (blob_byte),
		.last_blob_byte (last_blob_byte),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic parse_state_t idle_parser();
		parse_state_t s;
		s.max_len   = fhp_pkg::MAX_BLOB_LEN_RST;
		s.hdr_cnt   = 0;
		s.obj_key   = '0;
		s.frag_key  = '0;
		s.flags     = '0;
		s.length    = '0;
		s.blob_left = '0;
		return s;
	endfunction

	// Advance the decoder by one byte. Returns 1 when the byte yields a report.
	function automatic bit decode_byte(inout parse_state_t s, input logic [7:0] b,
			output frag_report_t r);
		if (s.blob_left != 0) begin
			// payload: pass the byte through, flag the final one
			s.blob_left--;
			r.kind      = fhp_pkg::KIND_BLOB;
			r.data      = b;
			r.last_byte = (s.blob_left == 0);
		end else begin
			// header: shift the byte into its field, MSB first
			if (s.hdr_cnt < fhp_pkg::OBJ_END)
				s.obj_key = {s.obj_key[55:0], b};
			else if (s.hdr_cnt < fhp_pkg::FRG_END)
				s.frag_key = {s.frag_key[55:0], b};
			else if (s.hdr_cnt == fhp_pkg::FLAGS_POS)
				s.flags = b;
			else
				s.length = {s.length[23:0], b};
			if (s.hdr_cnt + 1 < fhp_pkg::HDR_BYTES) begin
				s.hdr_cnt++;
				return 1'b0;
			end
			s.hdr_cnt   = 0;
			r.data      = 8'h00;
			r.last_byte = 1'b0;
			// an oversize length wins over a zero object id
			if (s.length > s.max_len)
				r.kind = fhp_pkg::KIND_LEN_ERR;
			else if (s.obj_key == '0)
				r.kind = fhp_pkg::KIND_ZERO_ID;
			else begin
				r.kind      = fhp_pkg::KIND_HDR_OK;
				s.blob_left = s.length;
			end
		end
		// every report carries the fields of the header it belongs to
		r.obj_key   = s.obj_key;
		r.frag_key  = s.frag_key;
		r.start_bit = s.flags[0];
		r.end_bit   = s.flags[1];
		r.length    = s.length;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stream building: every byte goes through the planning decoder, so the
	// builder always knows where the core will stand when the byte arrives.
	// ------------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b);
		frag_report_t unused;
		pending_bytes.push_back(b);
		void'(decode_byte(plan_state, b, unused));
		planned_bytes++;
	endtask

	// Append a fragment. If a truncated header is still open, its bytes take
	// the place of the leading bytes of this one. Append the whole payload
	// whenever the header is accepted.
	task automatic add_fragment(input logic [63:0] obj, input logic [63:0] frg,
			input logic [7:0] flags, input logic [31:0] len);
		logic [167:0] hdr;
		hdr = {obj, frg, flags, len};
		for (int i = plan_state.hdr_cnt; i < fhp_pkg::HDR_BYTES; i++)
			add_byte(hdr[167 - 8 * i -: 8]);
		while (plan_state.blob_left != 0)
			add_byte(8'($urandom));
	endtask

	function automatic logic [63:0] pick_ident();
		case ($urandom_range(19))
			0, 1: return '0;
			2:    return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Pick a blob length: mostly short payloads, some right at or just past
	// the limit, some wide random values. Any accepted length stays short.
	function automatic logic [31:0] pick_length(input logic [31:0] lim);
		int unsigned roll;
		logic [31:0] n;
		roll = $urandom_range(99);
		if (roll < 15)
			return '0;
		if (roll < 65)
			return $urandom_range(lim < 12 ? lim : 12);
		if (roll < 80) begin
			if (lim < 48)
				return lim + $urandom_range(1);
			if (lim != '1)
				return lim + 1;
			return $urandom_range(12);
		end
		n = $urandom;
		return (n > lim) ? n : (n & 32'hF);
	endfunction

	// Random stream: mostly fragments with random content, the rest truncated
	// headers. Noise never reaches the length bytes, so payloads stay short.
	task automatic add_random_stream(input int unsigned count);
		planned_bytes = 0;
		while (planned_bytes < count) begin
			if ($urandom_range(99) < 12 && plan_state.hdr_cnt <= 15)
				repeat ($urandom_range(16 - plan_state.hdr_cnt, 1))
					add_byte(8'($urandom));
			else
				add_fragment(pick_ident(), pick_ident(), 8'($urandom),
					pick_length(plan_state.max_len));
		end
		// close the phase on a fragment boundary
		add_fragment(pick_ident(), pick_ident(), 8'($urandom),
			pick_length(plan_state.max_len));
	endtask

	// Hold until the stream is sent and every report has come, then let the
	// core settle.
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [31:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		plan_state.max_len = v;
	endtask

	// ------------------------------------------------------------------------
	// Sender: offer the next byte at the falling edge. Hold the byte until it
	// is taken; idle at random between bytes.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : feed_p
		logic       offer;
		logic [7:0] data;
		offer = in_valid;
		data  = in_byte;
		if (arst_n && (in_taken || !in_valid)) begin
			offer = 1'b0;
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offer = 1'b1;
				data  = pending_bytes.pop_front();
			end
		end
		in_valid <= offer;
		in_byte  <= data;
	end

	// Receiver: stall at random, or for a long stretch on request so that
	// the core fills up and pushes back on its input.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left     = 200;
			out_stall     <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// ------------------------------------------------------------------------
	// Scoreboard at the rising edge: track register writes, decode accepted
	// bytes first, then check the report that leaves the core.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : score_p
		frag_report_t got_next;
		frag_report_t want;
		if (arst_n) begin
			if (cfg_we)
				parser_state.max_len = cfg_wdata;
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				if (decode_byte(parser_state, in_byte, got_next))
					reports_due.push_back(got_next);
			end
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$display("%0t: report mismatch: expected none, actual kind %0d",
						$time, kind);
					error_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("kind", want.kind, kind);
					check_field("object_ident", want.obj_key, object_ident);
					check_field("fragment_ident", want.frag_key, fragment_ident);
					check_field("start_flag", want.start_bit, start_flag);
					check_field("end_flag", want.end_bit, end_flag);
					check_field("blob_length", want.length, blob_length);
					check_field("blob_byte", want.data, blob_byte);
					check_field("last_blob_byte", want.last_byte, last_blob_byte);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] lim;
		parser_state = idle_parser();
		plan_state   = idle_parser();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset limit
		send_idle_pct = 34;
		recv_idle_pct = 53;
		add_fragment('1, '0, 8'hFF, 32'd1);                 // extremes, reserved flags set
		add_fragment(64'h1, '1, 8'h00, 32'd0);              // empty payload
		add_fragment(64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0001, 8'h01, 32'd5);
		add_fragment(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFE, 8'h02, 32'd3);
		add_fragment('0, 64'h5555_AAAA_5555_AAAA, 8'h03, 32'd2);       // zero id
		add_fragment('0, '1, 8'hFC, 32'hFFFF_FFFF);         // both errors: length wins
		add_fragment(64'hFEED_0000_0000_BEEF, 64'h1, 8'h00, 32'h0001_0000);
		repeat (9) add_byte(8'($urandom));                  // truncated header
		add_fragment(64'h7, 64'h7, 8'h01, 32'd4);
		add_fragment(64'hAAAA_5555_AAAA_5555, '0, 8'h02, 32'd0);
		wait_drained();

		// Random phases, each under its own limit, in pairs that share an idling mode
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: lim = 32'd0;
				1: lim = 32'hFFFF_FFFF;
				2: lim = 32'd20;
				3: lim = fhp_pkg::MAX_BLOB_LEN_RST;
				4: lim = $urandom_range(47, 1);
				default: lim = $urandom;
			endcase
			send_idle_pct = (p < 2) ? 34 : (p < 4) ? 53 : 0;
			recv_idle_pct = (p < 2) ? 53 : (p < 4) ? 34 : 0;
			write_max_len(lim);
			add_random_stream(205);
			if (p == 1) begin
				// let traffic start, then block the output for a long stretch
				repeat (40) @(posedge clk);
				long_hold_req = 1'b1;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("** fragment_header_parser_core: PASSED **");
		else
			$display("** fragment_header_parser_core: FAILED **");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("** fragment_header_parser_core: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/fhp_pkg.sv
hw/rtl/fragment_header_parser_core.sv
hw/rtl/fhp_checker.sv
dv/tb_fragment_header_parser_core.sv
